// File: hw/rtl/gfdot_pkg.sv
// gfdot_pkg: shared constants, types and the GF(2^8) multiply for the
// erasure-code dot product block. No dependencies.
`default_nettype none

package gfdot_pkg;

  // lane and row counts
  localparam int unsigned MAX_SOURCES = 8;
  localparam int unsigned MAX_OUTPUTS = 4;

  // field and register widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SRC_W     = MAX_SOURCES * BYTE_W;
  localparam int unsigned CODED_W   = MAX_OUTPUTS * BYTE_W;
  localparam int unsigned NSRC_W    = 4;
  localparam int unsigned NOUT_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned ROW_IDX_W = 2;

  // reset values of the configuration registers
  localparam logic [NSRC_W-1:0] NSRC_RST = NSRC_W'(8);
  localparam logic [NOUT_W-1:0] NOUT_RST = NOUT_W'(4);
  localparam logic [BYTE_W-1:0] POLY_RST = BYTE_W'(8'h1D);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_ROW0   = 3'd0,
    CFG_COEF_ROW1   = 3'd1,
    CFG_COEF_ROW2   = 3'd2,
    CFG_COEF_ROW3   = 3'd3,
    CFG_NUM_SOURCES = 3'd4,
    CFG_NUM_OUTPUTS = 3'd5,
    CFG_FIELD_POLY  = 3'd6
  } cfg_idx_e;

  // control passed from the pipeline control to the merge stage
  typedef struct packed {
    logic load;
    logic last;
  } stage_ctl_t;

  typedef logic [MAX_OUTPUTS-1:0][BYTE_W-1:0] row_bytes_t;

  // shift-and-reduce multiply, x^8 implied above poly
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      if (x[BYTE_W-1]) begin
        x = {x[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        x = {x[BYTE_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gfdot_lane.sv
// gfdot_lane: one source lane, multiplies its byte by every row coefficient
// and registers the products. Depends on gfdot_pkg.
`default_nettype none

module gfdot_lane
  import gfdot_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [BYTE_W-1:0] src_i,
  input  wire row_bytes_t        coef_i,
  input  wire logic [BYTE_W-1:0] poly_i,
  output row_bytes_t             prod_o
);

  row_bytes_t prod_d;
  row_bytes_t prod_q;

  // one multiplier per output row
  always_comb begin
    for (int l = 0; l < MAX_OUTPUTS; l++) begin
      prod_d[l] = gf_mul(src_i, coef_i[l], poly_i);
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: hw/rtl/gfdot_merge.sv
// gfdot_merge: XORs the products of the active lanes per row, zeroes rows
// beyond the row count and holds the output register. Depends on gfdot_pkg.
`default_nettype none

module gfdot_merge
  import gfdot_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire stage_ctl_t                   ctl_i,
  input  wire row_bytes_t [MAX_SOURCES-1:0] prod_i,
  input  wire logic [NSRC_W-1:0]            num_sources_i,
  input  wire logic [NOUT_W-1:0]            num_outputs_i,
  output logic [CODED_W-1:0]                coded_o,
  output logic                              last_o
);

  row_bytes_t sum_d;
  row_bytes_t sum_q;
  logic       last_q;

  // xor over active lanes, masked by row count
  always_comb begin
    for (int l = 0; l < MAX_OUTPUTS; l++) begin
      sum_d[l] = '0;
      for (int j = 0; j < MAX_SOURCES; j++) begin
        if (NSRC_W'(j) < num_sources_i) begin
          sum_d[l] = sum_d[l] ^ prod_i[j][l];
        end
      end
      if (!(NOUT_W'(l) < num_outputs_i)) begin
        sum_d[l] = '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sum_q  <= sum_d;
      last_q <= ctl_i.last;
    end
  end

  assign coded_o = sum_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/gf256_erasure_code_dot_product.sv
// gf256_erasure_code_dot_product: top level with configuration registers,
// eight product lanes, merge stage and pipeline control.
// Depends on gfdot_pkg, gfdot_lane and gfdot_merge.
//
//   channel   | direction | handshake               | payload
//   ----------+-----------+-------------------------+-----------------------------
//   in        | input     | in_valid_i / in_stall_o | source_bytes_i, end_of_chunk_i
//   out       | output    | out_valid_o/out_stall_i | coded_bytes_o, chunk_last_o
//   cfg       | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; each item passes from input
// transfer to a valid result through the lane product register, then the merge/output register
// reset clears the pipeline valid bits and loads the register defaults
// a stalled output holds; input stalls only while both stages are full
// configuration writes are always ready and take effect once registered
`default_nettype none

module gf256_erasure_code_dot_product
  import gfdot_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [SRC_W-1:0]     source_bytes_i,
  input  wire logic                 end_of_chunk_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CODED_W-1:0]        coded_bytes_o,
  output logic                      chunk_last_o,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  // configuration registers
  logic [MAX_OUTPUTS-1:0][SRC_W-1:0] coef_d, coef_q;
  logic [NSRC_W-1:0]                 nsrc_d, nsrc_q;
  logic [NOUT_W-1:0]                 nout_d, nout_q;
  logic [BYTE_W-1:0]                 poly_d, poly_q;

  // pipeline control
  logic       s1_valid_d, s1_valid_q;
  logic       s2_valid_d, s2_valid_q;
  logic       s1_last_q;
  logic       s1_load, s2_free;
  stage_ctl_t merge_ctl;

  row_bytes_t [MAX_SOURCES-1:0] lane_coef;
  row_bytes_t [MAX_SOURCES-1:0] lane_prod;

  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    coef_d = coef_q;
    nsrc_d = nsrc_q;
    nout_d = nout_q;
    poly_d = poly_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i) inside
        CFG_COEF_ROW0, CFG_COEF_ROW1, CFG_COEF_ROW2, CFG_COEF_ROW3: begin
          coef_d[cfg_index_i[ROW_IDX_W-1:0]] = cfg_data_i[SRC_W-1:0];
        end
        CFG_NUM_SOURCES: begin
          nsrc_d = cfg_data_i[NSRC_W-1:0];
        end
        CFG_NUM_OUTPUTS: begin
          nout_d = cfg_data_i[NOUT_W-1:0];
        end
        CFG_FIELD_POLY: begin
          poly_d = cfg_data_i[BYTE_W-1:0];
        end
        default: begin
          // index beyond the register list: write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      nsrc_q <= NSRC_RST;
      nout_q <= NOUT_RST;
      poly_q <= POLY_RST;
    end else begin
      coef_q <= coef_d;
      nsrc_q <= nsrc_d;
      nout_q <= nout_d;
      poly_q <= poly_d;
    end
  end

  // two-stage pipeline with per-stage valid
  assign s2_free         = !s2_valid_q || !out_stall_i;
  assign in_stall_o      = s1_valid_q && !s2_free;
  assign s1_load         = in_valid_i && !in_stall_o;
  assign merge_ctl.load  = s1_valid_q && s2_free;
  assign merge_ctl.last  = s1_last_q;
  assign s1_valid_d      = s1_load || (s1_valid_q && !merge_ctl.load);
  assign s2_valid_d      = merge_ctl.load || (s2_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // end-of-chunk flag alongside the lane products
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_last_q <= end_of_chunk_i;
    end
  end

  // product lanes
  for (genvar j = 0; j < MAX_SOURCES; j++) begin : g_lane
    for (genvar l = 0; l < MAX_OUTPUTS; l++) begin : g_coef
      assign lane_coef[j][l] = coef_q[l][BYTE_W*j +: BYTE_W];
    end

    gfdot_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (s1_load),
      .src_i  (source_bytes_i[BYTE_W*j +: BYTE_W]),
      .coef_i (lane_coef[j]),
      .poly_i (poly_q),
      .prod_o (lane_prod[j])
    );
  end

  // merge and output register
  gfdot_merge u_merge (
    .clk_i         (clk_i),
    .ctl_i         (merge_ctl),
    .prod_i        (lane_prod),
    .num_sources_i (nsrc_q),
    .num_outputs_i (nout_q),
    .coded_o       (coded_bytes_o),
    .last_o        (chunk_last_o)
  );

  assign out_valid_o = s2_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/gfdot_checker.sv
// gfdot_assert: port-level assertions for the dot product block, bound to
// the top level. Depends on gfdot_pkg.
`default_nettype none

module gfdot_assert
  import gfdot_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 end_of_chunk_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [CODED_W-1:0]   coded_bytes_o,
  input wire logic                 chunk_last_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coded_bytes_o)
      && $stable(chunk_last_o))
    else $error("stalled result changed");

  // input is never stalled while the output register is empty
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // an accepted item shows up as a valid result when the output drains
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after transfer");

  // accepted end-of-chunk flag reaches the output when nothing stalls
  a_last_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && end_of_chunk_i) ##1 !out_stall_i
      |=> out_valid_o && chunk_last_o)
    else $error("end-of-chunk flag lost");

endmodule

bind gf256_erasure_code_dot_product gfdot_assert u_gfdot_assert (.*);

`default_nettype wire
